>>> hdl/wlcsd_pkg.sv
// Package for the wide-lane cycle-slip detector: field widths, payload structs,
// register indexes and the command/status structs between controller and datapath.
// No dependencies.
package wlcsd_pkg;

	localparam int SAMPLE_W      = 40;
	localparam int VAR_W         = 48;
	localparam int IDX_W         = 20;
	localparam int FACTOR_W      = 8;
	localparam int CFG_W         = 32;
	localparam int CFG_IDX_W     = 2;
	localparam int FRAC_BITS_DEF = 16;

	// Serial units: magnitude of a deviation, its square, the outlier threshold,
	// the rounded square and the dividend of every division.
	localparam int MUL_W  = SAMPLE_W + 1;
	localparam int PROD_W = 2 * MUL_W;
	localparam int THR_W  = FACTOR_W + VAR_W;
	localparam int SQR_W  = THR_W;
	localparam int DIV_W  = SQR_W + 2;

	localparam logic [CFG_IDX_W-1:0] CFG_OUTLIER_FACTOR   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_VARIANCE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLIP_WINDOW      = 2'd2;

	localparam logic [2:0] CK_OPEN    = 3'd0;
	localparam logic [2:0] CK_ADVANCE = 3'd1;
	localparam logic [2:0] CK_OUTLIER = 3'd2;
	localparam logic [2:0] CK_SLIP    = 3'd3;
	localparam logic [2:0] CK_UPDATE  = 3'd4;

	localparam logic [1:0] DS_MEAN = 2'd0;
	localparam logic [1:0] DS_VAR  = 2'd1;
	localparam logic [1:0] DS_MV   = 2'd2;

	localparam logic EV_OUTLIER = 1'b0;
	localparam logic EV_SLIP    = 1'b1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last_sample;
	} wlcsd_in_t;

	typedef struct packed {
		logic                       event_kind;
		logic [IDX_W-1:0]           epoch_index;
		logic signed [SAMPLE_W-1:0] arc_mean;
		logic [VAR_W-1:0]           arc_mean_variance;
		logic [IDX_W-1:0]           arc_points;
	} wlcsd_out_t;

	typedef struct packed {
		logic       load;
		logic       prep;
		logic       cmp;
		logic       div_start;
		logic [1:0] div_sel;
		logic       save_mean;
		logic       commit;
		logic [2:0] kind;
	} wlcsd_cmd_t;

	typedef struct packed {
		logic started;
		logic pend_valid;
		logic mul_busy;
		logic div_busy;
		logic outlier;
		logic slip_ok;
		logic out_free;
	} wlcsd_sts_t;

endpackage

>>> hdl/widelane_cycle_slip_detector.sv
// Top level of the wide-lane cycle-slip detector: controller plus datapath.
// Depends on wlcsd_pkg, wlcsd_ctrl and wlcsd_dp.
//
// The block takes wide-lane samples (signed Q23.16 cycles) one item at a time
// and keeps the running mean and variance of the current arc. Each sample is
// judged when the next one arrives, so every record lags the input by one
// item. An outlier record (event_kind 0) names the index of a sample whose
// squared deviation exceeds outlier_factor times the variance. A slip record
// (event_kind 1) follows when the next sample is an outlier too and lies
// within slip_window of its successor; it withdraws the outlier just reported,
// closes the arc and carries its mean, variance over point count and points.
// An item with last_sample set ends the series, and the next item opens a new
// one. Throughput is set by two serial units in the datapath: a shift-and-add
// multiplier that forms the squared deviation one bit per cycle and a
// restoring divider that produces one quotient bit per cycle. The first sample
// of a series and the one after it use neither unit. A judged sample uses the
// multiplier alone when it is an outlier, the multiplier and one division when
// it closes the arc, and the multiplier and two divisions when it updates the
// mean and variance. A finished record waits in an output register, so the
// next item is accepted while the record is still pending downstream; a later
// outlier or slip record that finds that register still occupied waits in the
// controller, and the input stays blocked until the receiver takes the first.
// Configuration is written through cfg_we, cfg_idx and cfg_wdata, by the user
// only while the block is idle, which the block does not enforce. Index 0 is
// outlier_factor, 1 initial_variance and 2 slip_window; others are ignored.
module widelane_cycle_slip_detector import wlcsd_pkg::*; #(
	parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  wlcsd_in_t            in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output wlcsd_out_t           out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	// Command and status travel as structs between the two halves.
	wlcsd_cmd_t cmd;
	wlcsd_sts_t sts;

	wlcsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wlcsd_dp #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

>>> hdl/wlcsd_ctrl.sv
// Controller of the wide-lane cycle-slip detector: sequences one item at a time
// through the serial multiplier and divider of the datapath. Depends on wlcsd_pkg.
module wlcsd_ctrl import wlcsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  wlcsd_sts_t sts,
	output wlcsd_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_DECIDE   = 3'd1;
	localparam logic [2:0] ST_MUL      = 3'd2;
	localparam logic [2:0] ST_CMP      = 3'd3;
	localparam logic [2:0] ST_DIV_MEAN = 3'd4;
	localparam logic [2:0] ST_DIV_VAR  = 3'd5;
	localparam logic [2:0] ST_DIV_MV   = 3'd6;
	localparam logic [2:0] ST_COMMIT   = 3'd7;

	logic [2:0] state_q, state_d;
	logic [2:0] kind_q, kind_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= CK_ADVANCE;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (!sts.started) begin
					cmd.commit = 1'b1;
					cmd.kind   = CK_OPEN;
					state_d    = ST_IDLE;
				end else if (!sts.pend_valid) begin
					cmd.commit = 1'b1;
					cmd.kind   = CK_ADVANCE;
					state_d    = ST_IDLE;
				end else begin
					cmd.prep = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				if (!sts.mul_busy) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				cmd.cmp = 1'b1;
				if (sts.outlier && sts.slip_ok) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DS_MV;
					state_d       = ST_DIV_MV;
				end else if (sts.outlier) begin
					kind_d  = CK_OUTLIER;
					state_d = ST_COMMIT;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DS_MEAN;
					state_d       = ST_DIV_MEAN;
				end
			end
			ST_DIV_MEAN: begin
				if (!sts.div_busy) begin
					cmd.save_mean = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel   = DS_VAR;
					state_d       = ST_DIV_VAR;
				end
			end
			ST_DIV_VAR: begin
				if (!sts.div_busy) begin
					kind_d  = CK_UPDATE;
					state_d = ST_COMMIT;
				end
			end
			ST_DIV_MV: begin
				if (!sts.div_busy) begin
					kind_d  = CK_SLIP;
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				// Outlier and slip records need the output register to be free.
				if (kind_q == CK_UPDATE || sts.out_free) begin
					cmd.commit = 1'b1;
					cmd.kind   = kind_q;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> hdl/wlcsd_dp.sv
// Datapath of the wide-lane cycle-slip detector: arc state, configuration
// registers, serial multiplier, serial divider and output register. Depends on wlcsd_pkg.
module wlcsd_dp import wlcsd_pkg::*; #(
	parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wlcsd_in_t            in_data,
	output wlcsd_out_t           out_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  wlcsd_cmd_t           cmd,
	output wlcsd_sts_t           sts
);

	localparam int MCNT_W = $clog2(MUL_W + 1);
	localparam int DCNT_W = $clog2(DIV_W + 1);
	localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};
	localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

	// Configuration
	logic [FACTOR_W-1:0] factor_q;
	logic [CFG_W-1:0]    init_var_q;
	logic [CFG_W-1:0]    window_q;

	// Arc state
	logic signed [SAMPLE_W-1:0] mean_q;
	logic [VAR_W-1:0]           var_q;
	logic [IDX_W-1:0]           count_q;
	logic [IDX_W-1:0]           epoch_q;
	logic                       prev_q, started_q, pv_q;
	logic signed [SAMPLE_W-1:0] pend_q;

	// Current item and work registers
	logic signed [SAMPLE_W-1:0] x_q;
	logic                       last_q;
	logic [MUL_W-1:0]           mag_q;
	logic                       dneg_q, vneg_q, gap_ok_q;
	logic [THR_W-1:0]           thr_q;
	logic [SQR_W-1:0]           sqr_q;
	logic [DIV_W-1:0]           meanq_q;

	// Serial multiplier
	logic [MCNT_W-1:0] mul_cnt_q;
	logic [MUL_W-1:0]  mplier_q;
	logic [PROD_W-1:0] mcand_q, acc_q;

	// Serial divider
	logic [DCNT_W-1:0] div_cnt_q;
	logic [DIV_W-1:0]  quo_q;
	logic [IDX_W:0]    rem_q;
	logic [IDX_W-1:0]  dvsr_q;

	wlcsd_out_t out_q;
	logic       out_valid_q;

	// Deviation of the pending sample from the mean, and its gap to the new sample.
	logic signed [SAMPLE_W:0] dev, gap;
	logic [MUL_W-1:0]         dev_mag, gap_mag;
	assign dev     = {pend_q[SAMPLE_W-1], pend_q} - {mean_q[SAMPLE_W-1], mean_q};
	assign gap     = {pend_q[SAMPLE_W-1], pend_q} - {x_q[SAMPLE_W-1], x_q};
	assign dev_mag = dev[SAMPLE_W] ? MUL_W'(-dev) : MUL_W'(dev);
	assign gap_mag = gap[SAMPLE_W] ? MUL_W'(-gap) : MUL_W'(gap);

	logic [PROD_W-1:0] thr_shift, sq_round;
	assign thr_shift = PROD_W'(thr_q) << FRACTION_BITS;
	assign sq_round  = acc_q + (PROD_W'(1) << (FRACTION_BITS - 1));

	logic [IDX_W-1:0] pts, half_cnt;
	assign pts      = count_q - IDX_W'(1);
	assign half_cnt = count_q >> 1;

	logic             sqr_ge;
	logic [SQR_W:0]   dmag;
	assign sqr_ge = sqr_q >= SQR_W'(var_q);
	assign dmag   = sqr_ge ? (SQR_W + 1)'(sqr_q - SQR_W'(var_q))
	                       : (SQR_W + 1)'(SQR_W'(var_q) - sqr_q);

	logic [DIV_W-1:0] dvnd;
	logic [IDX_W-1:0] dvsr;
	always_comb begin
		case (cmd.div_sel)
			DS_MEAN: begin
				dvnd = DIV_W'(mag_q) + DIV_W'(half_cnt);
				dvsr = count_q;
			end
			DS_VAR: begin
				dvnd = DIV_W'(dmag) + DIV_W'(half_cnt);
				dvsr = count_q;
			end
			default: begin
				dvnd = DIV_W'(var_q) + DIV_W'(pts >> 1);
				dvsr = pts;
			end
		endcase
	end

	logic [IDX_W:0] rem_sh;
	logic           rem_ge;
	assign rem_sh = {rem_q[IDX_W-1:0], quo_q[DIV_W-1]};
	assign rem_ge = rem_sh >= {1'b0, dvsr_q};

	// Arc update: rounded mean step and variance step, variance saturated.
	logic signed [SAMPLE_W+1:0] mean_step, mean_new;
	logic signed [DIV_W+1:0]    vq, var_new;
	assign mean_step = dneg_q ? -(SAMPLE_W + 2)'(meanq_q) : (SAMPLE_W + 2)'(meanq_q);
	assign mean_new  = {{2{mean_q[SAMPLE_W-1]}}, mean_q} + mean_step;
	assign vq        = vneg_q ? -(DIV_W + 2)'(quo_q) : (DIV_W + 2)'(quo_q);
	assign var_new   = (DIV_W + 2)'(var_q) + vq;

	logic [VAR_W-1:0] var_sat;
	always_comb begin
		if (var_new[DIV_W+1]) begin
			var_sat = '0;
		end else if (var_new > (DIV_W + 2)'(VAR_MAX)) begin
			var_sat = VAR_MAX;
		end else begin
			var_sat = var_new[VAR_W-1:0];
		end
	end

	// A record is raised by an outlier or slip commit and dropped once it is taken.
	logic rec_commit;
	assign rec_commit = cmd.commit && (cmd.kind == CK_OUTLIER || cmd.kind == CK_SLIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q   <= FACTOR_W'(16);
			init_var_q <= CFG_W'(1) << (FRACTION_BITS - 2);
			window_q   <= CFG_W'(1) << FRACTION_BITS;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_OUTLIER_FACTOR:   factor_q   <= cfg_wdata[FACTOR_W-1:0];
				CFG_INITIAL_VARIANCE: init_var_q <= cfg_wdata;
				CFG_SLIP_WINDOW:      window_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q      <= '0;
			var_q       <= '0;
			count_q     <= IDX_W'(2);
			epoch_q     <= '0;
			prev_q      <= 1'b0;
			started_q   <= 1'b0;
			pv_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (out_valid_q && !out_ready) || rec_commit;
			if (cmd.commit) begin
				// The last sample of a series rearms the block for a new one.
				started_q <= !last_q;
				pv_q      <= (cmd.kind != CK_OPEN) && !last_q;
				if (cmd.kind == CK_OPEN) begin
					mean_q  <= x_q;
					var_q   <= VAR_W'(init_var_q);
					count_q <= IDX_W'(2);
					prev_q  <= 1'b0;
					epoch_q <= '0;
				end else begin
					epoch_q <= epoch_q + IDX_W'(1);
				end
				case (cmd.kind)
					CK_OUTLIER: begin
						prev_q <= 1'b1;
					end
					CK_SLIP: begin
						mean_q  <= pend_q;
						var_q   <= VAR_W'(init_var_q);
						count_q <= IDX_W'(2);
						prev_q  <= 1'b0;
					end
					CK_UPDATE: begin
						mean_q  <= mean_new[SAMPLE_W-1:0];
						var_q   <= var_sat;
						prev_q  <= 1'b0;
						if (count_q < IDX_MAX) begin
							count_q <= count_q + IDX_W'(1);
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= in_data.sample;
			last_q <= in_data.last_sample;
		end
		if (cmd.commit && cmd.kind != CK_OPEN) begin
			pend_q <= x_q;
		end
		if (cmd.commit && cmd.kind == CK_OUTLIER) begin
			out_q.event_kind        <= EV_OUTLIER;
			out_q.epoch_index       <= epoch_q;
			out_q.arc_mean          <= '0;
			out_q.arc_mean_variance <= '0;
			out_q.arc_points        <= '0;
		end
		if (cmd.commit && cmd.kind == CK_SLIP) begin
			out_q.event_kind        <= EV_SLIP;
			out_q.epoch_index       <= epoch_q - IDX_W'(1);
			out_q.arc_mean          <= mean_q;
			out_q.arc_mean_variance <= quo_q[VAR_W-1:0];
			out_q.arc_points        <= pts;
		end
		if (cmd.prep) begin
			mag_q    <= dev_mag;
			dneg_q   <= dev[SAMPLE_W];
			gap_ok_q <= gap_mag <= MUL_W'(window_q);
			thr_q    <= THR_W'(factor_q) * THR_W'(var_q);
		end
		if (cmd.cmp) begin
			sqr_q <= SQR_W'(sq_round >> FRACTION_BITS);
		end
		if (cmd.save_mean) begin
			meanq_q <= quo_q;
		end
		if (cmd.div_start && cmd.div_sel == DS_VAR) begin
			vneg_q <= !sqr_ge;
		end
	end

	// Shift-and-add multiplier, one bit of the multiplier per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_cnt_q <= '0;
		end else if (cmd.prep) begin
			mul_cnt_q <= MCNT_W'(MUL_W);
		end else if (mul_cnt_q != '0) begin
			mul_cnt_q <= mul_cnt_q - MCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			mplier_q <= dev_mag;
			mcand_q  <= PROD_W'(dev_mag);
			acc_q    <= '0;
		end else if (mul_cnt_q != '0) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mplier_q <= mplier_q >> 1;
			mcand_q  <= mcand_q << 1;
		end
	end

	// Restoring divider, one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_start) begin
			div_cnt_q <= DCNT_W'(DIV_W);
		end else if (div_cnt_q != '0) begin
			div_cnt_q <= div_cnt_q - DCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			quo_q  <= dvnd;
			rem_q  <= '0;
			dvsr_q <= dvsr;
		end else if (div_cnt_q != '0) begin
			rem_q <= rem_ge ? rem_sh - {1'b0, dvsr_q} : rem_sh;
			quo_q <= {quo_q[DIV_W-2:0], rem_ge};
		end
	end

	assign sts.started    = started_q;
	assign sts.pend_valid = pv_q;
	assign sts.mul_busy   = mul_cnt_q != '0;
	assign sts.div_busy   = div_cnt_q != '0;
	assign sts.outlier    = acc_q > thr_shift;
	assign sts.slip_ok    = prev_q && gap_ok_q;
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_data  = out_q;
	assign out_valid = out_valid_q;

endmodule

>>> hdl/wlcsd_checker.sv
// Port-level checker for the wide-lane cycle-slip detector, bound to the top level.
// Depends on wlcsd_pkg and widelane_cycle_slip_detector.
module wlcsd_checker import wlcsd_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input wlcsd_in_t            in_data,
	input logic                 out_valid,
	input logic                 out_ready,
	input wlcsd_out_t           out_data,
	input logic                 cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_idx,
	input logic [CFG_W-1:0]     cfg_wdata
);

	// A waiting record holds still until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output record changed while stalled");

	// One item at a time: an accepted item blocks the input for the next cycle.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after an accepted item");

	// Outlier records carry no arc summary.
	a_outlier_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_kind == EV_OUTLIER |->
		out_data.arc_points == '0 && out_data.arc_mean == '0 &&
		out_data.arc_mean_variance == '0)
		else $error("outlier record with arc summary");

	// A closed arc always has at least one point.
	a_slip_points: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_kind == EV_SLIP |-> out_data.arc_points != '0)
		else $error("slip record with no points");

endmodule

bind widelane_cycle_slip_detector wlcsd_checker u_chk (.*);

>>> verif/tb_widelane_cycle_slip_detector.sv
// Self-checking testbench for the wide-lane cycle-slip detector.
// Depends on wlcsd_pkg and the widelane_cycle_slip_detector RTL.
// An in-bench predictor of arc statistics checks every outlier and slip record.
module tb_widelane_cycle_slip_detector import wlcsd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  FRACTION_BITS = FRAC_BITS_DEF;
	localparam longint CYCLE_LIMIT = 2_000_000;
	localparam int  DRAIN_CYCLES = 250;   // comfortably above the longest update path
	localparam longint ONE = 64'sd1 <<< FRACTION_BITS;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	wlcsd_in_t            in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	wlcsd_out_t           out_data;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = CFG_OUTLIER_FACTOR;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	widelane_cycle_slip_detector dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	// Predicted register contents, kept in step with every write to the block.
	logic [FACTOR_W-1:0] factor_q;
	logic [31:0]         init_var_q;
	logic [31:0]         window_q;

	// Predicted arc state. Mean and variance fit easily in 64-bit signed values.
	longint          arc_mean_q;
	longint          arc_var_q;
	longint          arc_cnt_q;
	bit              prev_outlier_q;
	longint          held_sample_q;
	bit              held_valid_q;
	logic [IDX_W-1:0] epoch_q;
	bit              in_series_q;

	wlcsd_out_t record_q[$];   // records the block still owes us

	int     mismatches = 0;
	int     items_sent = 0;
	longint cycles = 0;
	bit     tx_gaps_on = 1'b1;
	bit     rx_stalls_on = 1'b1;
	int     rx_hold_req = 0;

	function automatic longint round_div(longint num, longint den);
		longint mag, q;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -q : q;
	endfunction

	// Judge the held sample now that its successor is known.
	task automatic judge_held(longint cur, longint nxt);
		longint dev, mag, gap, sq, v, pts;
		logic [127:0] dev_sq, limit;
		wlcsd_out_t rec;
		dev = cur - arc_mean_q;
		mag = (dev < 0) ? -dev : dev;
		dev_sq = 128'(mag) * 128'(mag);
		limit = (128'(factor_q) * 128'(arc_var_q)) << FRACTION_BITS;
		rec = '0;
		if (dev_sq > limit) begin
			gap = cur - nxt;
			if (gap < 0) gap = -gap;
			if (prev_outlier_q && gap <= longint'(window_q)) begin
				// Second outlier in a row with a close successor: the arc ends here.
				pts = arc_cnt_q - 1;
				rec.event_kind = EV_SLIP;
				rec.epoch_index = epoch_q - 1'b1;
				rec.arc_mean = arc_mean_q[SAMPLE_W-1:0];
				rec.arc_mean_variance = VAR_W'((arc_var_q + pts / 2) / pts);
				rec.arc_points = pts[IDX_W-1:0];
				record_q.insert(record_q.size(), rec);
				arc_mean_q = cur;
				arc_var_q = init_var_q;
				prev_outlier_q = 1'b0;
				arc_cnt_q = 2;
			end else begin
				rec.event_kind = EV_OUTLIER;
				rec.epoch_index = epoch_q;
				record_q.insert(record_q.size(), rec);
				prev_outlier_q = 1'b1;
			end
		end else begin
			sq = longint'((dev_sq + (128'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS);
			arc_mean_q += round_div(dev, arc_cnt_q);
			v = arc_var_q + round_div(sq - arc_var_q, arc_cnt_q);
			if (v < 0) v = 0;
			if (v > (64'sd1 <<< VAR_W) - 1) v = (64'sd1 <<< VAR_W) - 1;
			arc_var_q = v;
			if (arc_cnt_q < (1 << IDX_W) - 1) arc_cnt_q++;
			prev_outlier_q = 1'b0;
		end
	endtask

	task automatic track_sample(wlcsd_in_t it);
		longint x;
		x = longint'(it.sample);
		if (!in_series_q) begin
			arc_mean_q = x;
			arc_var_q = init_var_q;
			arc_cnt_q = 2;
			prev_outlier_q = 1'b0;
			epoch_q = '0;
			held_valid_q = 1'b0;
			in_series_q = 1'b1;
		end else begin
			if (held_valid_q) judge_held(held_sample_q, x);
			held_sample_q = x;
			epoch_q = epoch_q + 1'b1;
			held_valid_q = 1'b1;
		end
		if (it.last_sample) begin
			in_series_q = 1'b0;
			held_valid_q = 1'b0;
		end
	endtask

	// Offer one item. Entered and left at a falling edge; valid stays high on exit
	// so a back-to-back item keeps it high without a glitch.
	task automatic send_sample(longint value, bit last);
		int gap;
		wlcsd_in_t it;
		it.sample = value[SAMPLE_W-1:0];
		it.last_sample = last;
		gap = tx_gaps_on ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		track_sample(it);
		items_sent++;
		@(negedge clk);
	endtask

	// Stop offering and wait until the block has delivered everything and gone quiet.
	task automatic drain_all();
		in_valid <= 1'b0;
		while (record_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Drives one write for the next rising edge; the caller drops the enable.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		case (idx)
			CFG_OUTLIER_FACTOR:   factor_q = value[FACTOR_W-1:0];
			CFG_INITIAL_VARIANCE: init_var_q = value;
			CFG_SLIP_WINDOW:      window_q = value;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_regs(logic [CFG_W-1:0] fac, logic [CFG_W-1:0] iv, logic [CFG_W-1:0] win);
		drain_all();
		write_reg(CFG_OUTLIER_FACTOR, fac);
		write_reg(CFG_INITIAL_VARIANCE, iv);
		write_reg(CFG_SLIP_WINDOW, win);
		cfg_we <= 1'b0;
	endtask

	function automatic longint rand40();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return longint'(signed'(r[SAMPLE_W-1:0]));
	endfunction

	function automatic longint noise(int amp);
		return longint'($urandom_range(0, 2 * amp)) - amp;
	endfunction

	// One series around a level, with optional lone spikes and level jumps (slips).
	task automatic send_series(int len, longint level, int amp, int spike_pct, int jump_pct);
		longint x;
		for (int i = 0; i < len; i++) begin
			x = level + noise(amp);
			if ($urandom_range(0, 99) < jump_pct)
				level += ($urandom_range(0, 1) ? 1 : -1) * longint'($urandom_range(2, 60)) * ONE;
			else if ($urandom_range(0, 99) < spike_pct)
				x = level + ($urandom_range(0, 1) ? 1 : -1) * longint'($urandom_range(3, 40)) * ONE;
			send_sample(x, i == len - 1);
		end
	endtask

	// Field extremes, the one-sample series, and the final sample of a series.
	task automatic test_field_extremes();
		send_sample(64'sd0, 1'b1);                             // one-sample series
		send_sample((64'sd1 <<< 39) - 1, 1'b0);
		send_sample(-(64'sd1 <<< 39), 1'b0);
		send_sample((64'sd1 <<< 39) - 1, 1'b0);
		send_sample(-(64'sd1 <<< 39), 1'b0);
		send_sample(-64'sd1, 1'b1);
		send_sample(-(64'sd1 <<< 39), 1'b0);
		send_sample(-(64'sd1 <<< 39), 1'b0);
		send_sample((64'sd1 <<< 39) - 1, 1'b1);                // final sample only confirms
		drain_all();
	endtask

	// A clean arc, a lone outlier, then a level jump that must close the arc.
	task automatic test_outlier_and_slip();
		for (int i = 0; i < 6; i++) send_sample(ONE * 5 + noise(8000), 1'b0);
		send_sample(ONE * 12, 1'b0);                          // lone outlier
		for (int i = 0; i < 4; i++) send_sample(ONE * 5 + noise(8000), 1'b0);
		for (int i = 0; i < 5; i++) send_sample(ONE * 30 + noise(8000), i == 4);
		drain_all();
	endtask

	// Register extremes, including a zero factor and a zero window.
	task automatic test_register_sweep();
		set_regs(0, 1, 0);
		send_series(12, rand40() >>> 4, 20000, 10, 10);
		set_regs(255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_series(12, rand40(), 1 << 30, 10, 20);
		set_regs(1, 1, 32'hFFFF_FFFF);
		send_series(14, 64'sd0, 30000, 10, 15);
		set_regs(3, 32'h0010_0000, 32'h0008_0000);
		send_series(14, -(ONE * 1000), 60000, 10, 15);
		set_regs(16, 16384, 65536);
	endtask

	// Full receiver hold-off so the block backs up, then a wait for every record.
	task automatic test_backpressure();
		tx_gaps_on = 1'b0;
		rx_hold_req = 3000;
		send_series(25, ONE * 7, 10000, 20, 10);
		tx_gaps_on = 1'b1;
		drain_all();
	endtask

	task automatic test_random_series();
		int phase;
		phase = 0;
		while (items_sent < 440) begin
			if ($urandom_range(0, 9) == 0) begin
				tx_gaps_on = $urandom_range(0, 1);
				rx_stalls_on = $urandom_range(0, 1);
			end
			if ($urandom_range(0, 24) == 0 && phase < 4) begin
				phase++;
				set_regs($urandom_range(1, 64), $urandom_range(1000, 200000),
					$urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 1 << 20));
			end
			if ($urandom_range(0, 9) == 0)
				send_series($urandom_range(1, 4), rand40(), $urandom_range(0, 1 << 24), 30, 30);
			else
				send_series($urandom_range(5, 30), rand40() >>> $urandom_range(0, 12),
					$urandom_range(0, 20000), 6, 6);
		end
		drain_all();
	endtask

	// Receiver: random stalls per record, plus a long hold-off when asked.
	initial begin
		int n;
		@(negedge clk);
		forever begin
			n = rx_stalls_on ? $urandom_range(0, 14) : 0;
			n += rx_hold_req;
			rx_hold_req = 0;
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// Every accepted record is compared with the oldest prediction, field by field.
	always @(posedge clk) begin
		wlcsd_out_t want;
		bit bad;
		if (arst_n && out_valid && out_ready) begin
			if (record_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected record: kind %0d idx %0d", out_data.event_kind,
						out_data.epoch_index);
			end else begin
				want = record_q.pop_front();
				bad = (out_data.event_kind !== want.event_kind) ||
					(out_data.epoch_index !== want.epoch_index) ||
					(out_data.arc_mean !== want.arc_mean) ||
					(out_data.arc_mean_variance !== want.arc_mean_variance) ||
					(out_data.arc_points !== want.arc_points);
				if (bad) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp kind %0d idx %0d mean %0d mv %0d pts %0d",
							" / got %0d %0d %0d %0d %0d"},
							want.event_kind, want.epoch_index, want.arc_mean,
							want.arc_mean_variance, want.arc_points, out_data.event_kind,
							out_data.epoch_index, out_data.arc_mean,
							out_data.arc_mean_variance, out_data.arc_points);
				end
			end
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL widelane_cycle_slip_detector");
			$finish;
		end
	end

	initial begin
		factor_q = 16;
		init_var_q = 32'd16384;
		window_q = 32'd65536;
		arc_mean_q = 0;
		arc_var_q = 0;
		arc_cnt_q = 2;
		prev_outlier_q = 1'b0;
		held_sample_q = 0;
		held_valid_q = 1'b0;
		epoch_q = '0;
		in_series_q = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_field_extremes();
		test_outlier_and_slip();
		test_register_sweep();
		test_backpressure();
		test_random_series();
		if (mismatches == 0 && record_q.size() == 0)
			$display("PASS widelane_cycle_slip_detector");
		else
			$display("FAIL widelane_cycle_slip_detector");
		$finish;
	end

endmodule
